// ===== sv/pjbm_pkg.sv =====
// Package with shared constants, codes and command types for the jitter buffer mixer.
`timescale 1ns / 1ps
package pjbm_pkg;

  // Sizes of the peer buffers and the sample store.
  localparam int PEER_COUNT   = 8;
  localparam int JITTER_DEPTH = 4;
  localparam int FRAME_MAX    = 1024;

  // Item actions.
  localparam logic [1:0] ACT_PUSH  = 2'd0;
  localparam logic [1:0] ACT_PLAY  = 2'd1;
  localparam logic [1:0] ACT_DROP  = 2'd2;
  localparam logic [1:0] ACT_UNDEF = 2'd3;

  // Push status codes.
  localparam logic [1:0] ST_STORED  = 2'd0;
  localparam logic [1:0] ST_STALE   = 2'd1;
  localparam logic [1:0] ST_EVICTED = 2'd2;
  localparam logic [1:0] ST_NOPUSH  = 2'd3;

  // Configuration register indexes.
  localparam logic [0:0] REG_PRIME_DEPTH  = 1'd0;
  localparam logic [0:0] REG_FRAME_LENGTH = 1'd1;

  // Clip limits of the mix.
  localparam int SAMPLE_MAX = 32767;
  localparam int SAMPLE_MIN = -32768;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the input item
    logic exec;    // perform bookkeeping of a push, drop or play start
    logic rd_req;  // issue a memory read for the current peer
    logic acc;     // accumulate the sample returned by the memory
    logic finish;  // clip, pop, and drive the result
  } pjbm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_play;
    logic last_peer;
  } pjbm_sts_t;

endpackage

// ===== sv/pjbm_ctrl.sv =====
// Controller state machine that sequences one item through the datapath.
`timescale 1ns / 1ps
module pjbm_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  pjbm_pkg::pjbm_sts_t sts_i,
  output pjbm_pkg::pjbm_cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_READ = 3'd2;
  localparam logic [2:0] S_WAIT = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state_q, state_d;

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = sts_i.is_play ? S_READ : S_DONE;
      end
      S_READ: begin
        cmd_o.rd_req = 1'b1;
        state_d      = S_WAIT;
      end
      S_WAIT: begin
        cmd_o.acc = 1'b1;
        state_d   = sts_i.last_peer ? S_DONE : S_READ;
      end
      S_DONE: begin
        cmd_o.finish = 1'b1;
        state_d      = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

// ===== sv/pjbm_datapath.sv =====
// Datapath with peer bookkeeping, the sample memory and the mixing accumulator.
`timescale 1ns / 1ps
module pjbm_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pjbm_pkg::pjbm_cmd_t         cmd_i,
  output pjbm_pkg::pjbm_sts_t         sts_o,
  input  logic [1:0]                  action_i,
  input  logic [2:0]                  peer_i,
  input  logic [31:0]                 sequence_req_i,
  input  logic signed [15:0]          sample_in_i,
  input  logic                        frame_end_i,
  input  logic [2:0]                  prime_depth_i,
  input  logic [10:0]                 frame_length_i,
  output logic                        done_o,
  output logic signed [15:0]          mixed_sample_o,
  output logic                        frame_last_o,
  output logic [1:0]                  push_status_o,
  output logic [31:0]                 underrun_count_o,
  output logic [31:0]                 discard_count_o
);

  localparam int PEER_COUNT   = pjbm_pkg::PEER_COUNT;
  localparam int JITTER_DEPTH = pjbm_pkg::JITTER_DEPTH;
  localparam int FRAME_MAX    = pjbm_pkg::FRAME_MAX;

  localparam int PW  = (PEER_COUNT > 1) ? $clog2(PEER_COUNT) : 1;
  localparam int HW  = (JITTER_DEPTH > 1) ? $clog2(JITTER_DEPTH) : 1;
  localparam int CW  = $clog2(JITTER_DEPTH + 1);
  localparam int FW  = $clog2(FRAME_MAX);
  localparam int LW  = FW + 1;
  localparam int SLW = $clog2(PEER_COUNT * JITTER_DEPTH) > 0 ?
                       $clog2(PEER_COUNT * JITTER_DEPTH) : 1;
  localparam int SLOTS = PEER_COUNT * JITTER_DEPTH;
  localparam int SW  = 16 + $clog2(PEER_COUNT + 1);
  localparam int UW  = $clog2(PEER_COUNT + 1);

  // Captured item.
  logic [1:0]  act_q;
  logic [2:0]  peer_q;
  logic [31:0] seq_q;
  logic signed [15:0] smp_q;
  logic        fend_q;

  // Per-peer state.
  logic [PEER_COUNT-1:0] present_q, seen_q, priming_q, sel_q;
  logic [31:0] last_seq_q [PEER_COUNT];
  logic [HW-1:0] head_q [PEER_COUNT];
  logic [CW-1:0] count_q [PEER_COUNT];

  // Global state.
  logic [FW-1:0] play_idx_q;
  logic [LW-1:0] wr_idx_q;
  logic          in_frame_q, rejecting_q;
  logic [31:0]   under_q, disc_q;

  // Memories.
  logic signed [15:0] store_mem [SLOTS*FRAME_MAX];
  logic [LW-1:0]      len_mem [SLOTS];
  logic signed [15:0] rd_smp_q;
  logic [LW-1:0]      rd_len_q;
  logic               rd_en_q;

  // Mixing.
  logic [PW-1:0]      scan_q;
  logic signed [SW-1:0] sum_q;
  logic [1:0]         status_q;
  logic               flast_q;

  logic              pvalid;
  logic [PW-1:0]     p;
  logic [LW-1:0]     eff_len;

  assign pvalid = ({29'd0, peer_q} < PEER_COUNT);
  assign p      = peer_q[PW-1:0];

  // Effective frame length with odd values folded into range.
  always_comb begin
    if (frame_length_i == 11'd0) begin
      eff_len = LW'(1);
    end else if ({{(32-11){1'b0}}, frame_length_i} > FRAME_MAX) begin
      eff_len = LW'(FRAME_MAX);
    end else begin
      eff_len = LW'(frame_length_i);
    end
  end

  function automatic logic [SLW-1:0] slot_of(input logic [PW-1:0] pp,
                                             input logic [HW-1:0] pos);
    logic [31:0] s;
    s = 32'(pp) * JITTER_DEPTH + 32'(pos);
    return s[SLW-1:0];
  endfunction

  function automatic logic [HW-1:0] wrap_add(input logic [HW-1:0] h,
                                             input logic [CW-1:0] c);
    logic [31:0] s;
    s = (32'(h) + 32'(c)) % JITTER_DEPTH;
    return s[HW-1:0];
  endfunction

  function automatic logic [31:0] sat_inc(input logic [31:0] c);
    return (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
  endfunction

  // Push write target: pending slot and whether to write.
  logic          push_wr;
  logic [SLW-1:0] push_slot;
  logic          first_new, is_stale, evict_first;
  logic [HW-1:0] head_after;
  logic [CW-1:0] cnt_after;

  always_comb begin
    first_new   = !in_frame_q;
    is_stale    = first_new && seen_q[p] && (seq_q <= last_seq_q[p]);
    evict_first = first_new && !is_stale &&
                  ({{(32-CW){1'b0}}, count_q[p]} >= JITTER_DEPTH);
    head_after  = evict_first ? wrap_add(head_q[p], CW'(1)) : head_q[p];
    cnt_after   = evict_first ? count_q[p] - CW'(1) : count_q[p];
    push_slot   = slot_of(p, wrap_add(head_after, cnt_after));
    push_wr     = cmd_i.exec && (act_q == pjbm_pkg::ACT_PUSH) && pvalid &&
                  !(first_new ? is_stale : rejecting_q) &&
                  ((first_new ? LW'(0) : wr_idx_q) < LW'(FRAME_MAX));
  end

  // Sample memory, written on pushes and read during the play scan.
  logic [LW-1:0] wr_pos;
  assign wr_pos = first_new ? LW'(0) : wr_idx_q;

  always_ff @(posedge clk_i) begin
    if (push_wr) begin
      store_mem[{push_slot, wr_pos[FW-1:0]}] <= smp_q;
    end
    if (cmd_i.rd_req) begin
      rd_smp_q <= store_mem[{slot_of(scan_q, head_q[scan_q]), play_idx_q}];
    end
  end

  // Frame length memory, written at a push commit.
  logic          len_wr;
  logic [SLW-1:0] len_slot;
  logic [LW-1:0] len_val;
  always_ff @(posedge clk_i) begin
    if (len_wr) begin
      len_mem[len_slot] <= len_val;
    end
    if (cmd_i.rd_req) begin
      rd_len_q <= len_mem[slot_of(scan_q, head_q[scan_q])];
    end
  end

  // Bookkeeping and accumulation.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q  <= '0;
      seen_q     <= '0;
      priming_q  <= '1;
      sel_q      <= '0;
      for (int i = 0; i < PEER_COUNT; i++) begin
        last_seq_q[i] <= '0;
        head_q[i]     <= '0;
        count_q[i]    <= '0;
      end
      play_idx_q  <= '0;
      wr_idx_q    <= '0;
      in_frame_q  <= 1'b0;
      rejecting_q <= 1'b0;
      under_q     <= '0;
      disc_q      <= '0;
      scan_q      <= '0;
      sum_q       <= '0;
      status_q    <= pjbm_pkg::ST_NOPUSH;
      flast_q     <= 1'b0;
      rd_en_q     <= 1'b0;
      done_o      <= 1'b0;
    end else begin
      done_o  <= cmd_i.finish;
      rd_en_q <= cmd_i.rd_req && sel_q[scan_q];
      if (cmd_i.load) begin
        status_q <= pjbm_pkg::ST_NOPUSH;
        flast_q  <= 1'b0;
        sum_q    <= '0;
        scan_q   <= '0;
      end
      if (cmd_i.exec) begin
        case (act_q)
          pjbm_pkg::ACT_PUSH: begin
            if (pvalid) begin
              logic [31:0] dcnt;
              logic [HW-1:0] h;
              logic [CW-1:0] c;
              logic [1:0] st;
              logic rej;
              dcnt = disc_q;
              h    = head_q[p];
              c    = count_q[p];
              st   = pjbm_pkg::ST_STORED;
              rej  = rejecting_q;
              if (first_new) begin
                present_q[p] <= 1'b1;
                rej = is_stale;
                if (is_stale) begin
                  dcnt = sat_inc(dcnt);
                end else begin
                  seen_q[p]     <= 1'b1;
                  last_seq_q[p] <= seq_q;
                  if (evict_first) begin
                    h = head_after;
                    c = cnt_after;
                    dcnt = sat_inc(dcnt);
                    sel_q[p] <= 1'b0;
                    st = pjbm_pkg::ST_EVICTED;
                  end
                end
              end
              if (rej) begin
                st = pjbm_pkg::ST_STALE;
              end else if (fend_q) begin
                if ({{(32-CW){1'b0}}, c} >= JITTER_DEPTH) begin
                  h = wrap_add(h, CW'(1));
                  c = c - CW'(1);
                  dcnt = sat_inc(dcnt);
                  sel_q[p] <= 1'b0;
                  st = pjbm_pkg::ST_EVICTED;
                end
                c = c + CW'(1);
              end
              head_q[p]  <= h;
              count_q[p] <= c;
              disc_q     <= dcnt;
              status_q   <= st;
              if (fend_q) begin
                in_frame_q  <= 1'b0;
                rejecting_q <= 1'b0;
                wr_idx_q    <= '0;
              end else begin
                in_frame_q  <= 1'b1;
                rejecting_q <= rej;
                wr_idx_q    <= (push_wr) ? wr_pos + LW'(1) : wr_pos;
              end
            end
          end
          pjbm_pkg::ACT_DROP: begin
            if (pvalid) begin
              present_q[p]  <= 1'b0;
              seen_q[p]     <= 1'b0;
              last_seq_q[p] <= '0;
              priming_q[p]  <= 1'b1;
              head_q[p]     <= '0;
              count_q[p]    <= '0;
              sel_q[p]      <= 1'b0;
              in_frame_q    <= 1'b0;
              rejecting_q   <= 1'b0;
              wr_idx_q      <= '0;
            end
          end
          pjbm_pkg::ACT_PLAY: begin
            if (play_idx_q == '0) begin
              logic [PEER_COUNT-1:0] sel, prim;
              logic [UW-1:0] nund;
              logic [32:0] usum;
              sel  = '0;
              prim = priming_q;
              nund = '0;
              for (int i = 0; i < PEER_COUNT; i++) begin
                if (present_q[i]) begin
                  if (!(prim[i] && ({{(32-CW){1'b0}}, count_q[i]} <
                                    {29'd0, prime_depth_i}))) begin
                    prim[i] = 1'b0;
                    if (count_q[i] == '0) begin
                      nund = nund + UW'(1);
                      prim[i] = 1'b1;
                    end else begin
                      sel[i] = 1'b1;
                    end
                  end
                end
              end
              // One saturating add of all underruns found at this frame start.
              usum = {1'b0, under_q} + 33'(nund);
              sel_q     <= sel;
              priming_q <= prim;
              under_q   <= usum[32] ? 32'hFFFF_FFFF : usum[31:0];
            end
          end
          default: ;
        endcase
      end
      if (cmd_i.acc) begin
        if (rd_en_q && (LW'(play_idx_q) < rd_len_q)) begin
          sum_q <= sum_q + SW'(rd_smp_q);
        end
        scan_q <= scan_q + PW'(1);
      end
      if (cmd_i.finish) begin
        if (act_q == pjbm_pkg::ACT_PLAY) begin
          if (LW'(play_idx_q) + LW'(1) >= eff_len) begin
            flast_q <= 1'b1;
            for (int i = 0; i < PEER_COUNT; i++) begin
              if (sel_q[i] && count_q[i] != '0) begin
                head_q[i]  <= wrap_add(head_q[i], CW'(1));
                count_q[i] <= count_q[i] - CW'(1);
              end
            end
            sel_q      <= '0;
            play_idx_q <= '0;
          end else begin
            play_idx_q <= play_idx_q + FW'(1);
          end
        end
      end
    end
  end

  // Commit of the frame length on a push with frame end.
  always_comb begin
    logic [HW-1:0] h;
    logic [CW-1:0] c;
    h = head_after;
    c = cnt_after;
    if ({{(32-CW){1'b0}}, c} >= JITTER_DEPTH) begin
      h = wrap_add(h, CW'(1));
      c = c - CW'(1);
    end
    len_slot = slot_of(p, wrap_add(h, c));
    len_val  = push_wr ? wr_pos + LW'(1) : wr_pos;
    len_wr   = cmd_i.exec && (act_q == pjbm_pkg::ACT_PUSH) && pvalid && fend_q &&
               !(first_new ? is_stale : rejecting_q);
  end

  // Item capture.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q  <= action_i;
      peer_q <= peer_i;
      seq_q  <= sequence_req_i;
      smp_q  <= sample_in_i;
      fend_q <= frame_end_i;
    end
  end

  // Clipped output.
  always_comb begin
    if (sum_q > SW'(pjbm_pkg::SAMPLE_MAX)) begin
      mixed_sample_o = 16'sh7FFF;
    end else if (sum_q < SW'(pjbm_pkg::SAMPLE_MIN)) begin
      mixed_sample_o = -16'sh8000;
    end else begin
      mixed_sample_o = sum_q[15:0];
    end
  end

  assign frame_last_o     = flast_q;
  assign push_status_o    = status_q;
  assign underrun_count_o = under_q;
  assign discard_count_o  = disc_q;
  assign sts_o.is_play    = (act_q == pjbm_pkg::ACT_PLAY);
  assign sts_o.last_peer  = ({{(32-PW){1'b0}}, scan_q} == PEER_COUNT - 1);

endmodule

// ===== sv/peer_jitter_buffer_mixer.sv =====
// Top level of the per-peer jitter buffer mixer with its register port.
`timescale 1ns / 1ps
// One item is taken while busy_o is low and start_i is high; its single result
// appears for one cycle with done_o. Items other than play pass through the load,
// exec and done states; a play item also runs a scan that reads one stored
// sample per peer from the sample memory, in a read and a wait state per peer. The
// receiver cannot stall, so results must be sampled in the cycle of done_o.
// No clearing pass is needed after reset.
module peer_jitter_buffer_mixer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  output logic               done_o,
  input  logic [1:0]         action_i,
  input  logic [2:0]         peer_i,
  input  logic [31:0]        sequence_req_i,
  input  logic signed [15:0] sample_in_i,
  input  logic               frame_end_i,
  output logic signed [15:0] mixed_sample_o,
  output logic               frame_last_o,
  output logic [1:0]         push_status_o,
  output logic [31:0]        underrun_count_o,
  output logic [31:0]        discard_count_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  pjbm_pkg::pjbm_cmd_t cmd;
  pjbm_pkg::pjbm_sts_t sts;
  logic [2:0]  prime_q;
  logic [10:0] flen_q;
  logic        wr_en;

  // Configuration registers.
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prime_q <= 3'd2;
      flen_q  <= 11'd960;
    end else if (wr_en && paddr[1:0] == 2'd0) begin
      if (paddr[2] == pjbm_pkg::REG_PRIME_DEPTH) begin
        prime_q <= pwdata[2:0];
      end else begin
        flen_q <= pwdata[10:0];
      end
    end
  end

  // Register read-back.
  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'd0) begin
      case (paddr[2])
        pjbm_pkg::REG_PRIME_DEPTH:  prdata = {29'd0, prime_q};
        pjbm_pkg::REG_FRAME_LENGTH: prdata = {21'd0, flen_q};
        default: prdata = '0;
      endcase
    end
  end

  pjbm_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .sts_i   (sts),
    .cmd_o   (cmd)
  );

  pjbm_datapath u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .action_i         (action_i),
    .peer_i           (peer_i),
    .sequence_req_i   (sequence_req_i),
    .sample_in_i      (sample_in_i),
    .frame_end_i      (frame_end_i),
    .prime_depth_i    (prime_q),
    .frame_length_i   (flen_q),
    .done_o           (done_o),
    .mixed_sample_o   (mixed_sample_o),
    .frame_last_o     (frame_last_o),
    .push_status_o    (push_status_o),
    .underrun_count_o (underrun_count_o),
    .discard_count_o  (discard_count_o)
  );

  // An accepted item always makes the block busy.
  a_start_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted item did not make the block busy");

  // A result is shown only after the block was busy.
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy_o))
    else $error("result strobe without an item in flight");

  // Only play results carry a mix or frame mark.
  a_flast_play: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && frame_last_o) |-> (push_status_o == pjbm_pkg::ST_NOPUSH))
    else $error("frame mark on a push result");

endmodule

// ===== sim/mixer_checker.sv =====
// Checker that predicts and compares every result of the jitter buffer mixer.
`timescale 1ns / 1ps
module mixer_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_o,
  input  logic               done_o,
  input  logic [1:0]         action_i,
  input  logic [2:0]         peer_i,
  input  logic [31:0]        sequence_req_i,
  input  logic signed [15:0] sample_in_i,
  input  logic               frame_end_i,
  input  logic signed [15:0] mixed_sample_o,
  input  logic               frame_last_o,
  input  logic [1:0]         push_status_o,
  input  logic [31:0]        underrun_count_o,
  input  logic [31:0]        discard_count_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output int                 fail_count,
  output int                 pending_results
);
  localparam int NP = pjbm_pkg::PEER_COUNT;
  localparam int ND = pjbm_pkg::JITTER_DEPTH;
  localparam int FMAX = pjbm_pkg::FRAME_MAX;
  localparam int EXP_DEPTH = 8;

  typedef struct packed {
    logic signed [15:0] mixed;
    logic               last;
    logic [1:0]         status;
    logic [31:0]        underruns;
    logic [31:0]        discards;
  } mix_result_t;

  // Mirror of the block's state.
  logic [2:0]         depth_cfg;
  logic [10:0]        length_cfg;
  logic               present [NP];
  logic               seen [NP];
  logic [31:0]        last_seq [NP];
  logic               priming [NP];
  logic signed [15:0] samples [NP*ND*FMAX];
  int                 slot_len [NP*ND];
  int                 head [NP];
  int                 count [NP];
  logic [NP-1:0]      sel_mask;
  int                 play_pos;
  int                 write_pos;
  logic               in_frame;
  logic               rejecting;
  logic [31:0]        underruns;
  logic [31:0]        discards;

  // Ring of expected results still waiting for their transfer.
  mix_result_t        exp_ring [EXP_DEPTH];
  int                 exp_rd;
  int                 exp_wr;

  assign pending_results = exp_wr - exp_rd;

  function automatic logic [31:0] sat_inc(logic [31:0] c);
    return (c == 32'hFFFF_FFFF) ? c : c + 1;
  endfunction

  function automatic void drop_oldest(int p);
    head[p] = (head[p] + 1) % ND;
    count[p]--;
    discards = sat_inc(discards);
    sel_mask[p] = 1'b0;
  endfunction

  function automatic logic [1:0] apply_push(int p, logic [31:0] sq, logic signed [15:0] s,
                                            logic fe);
    logic [1:0] st;
    int slot;
    st = pjbm_pkg::ST_STORED;
    if (!in_frame) begin
      in_frame = 1; write_pos = 0; present[p] = 1;
      if (seen[p] && sq <= last_seq[p]) begin
        rejecting = 1; discards = sat_inc(discards);
      end else begin
        rejecting = 0; seen[p] = 1; last_seq[p] = sq;
        if (count[p] >= ND) begin
          drop_oldest(p); st = pjbm_pkg::ST_EVICTED;
        end
      end
    end
    if (rejecting) st = pjbm_pkg::ST_STALE;
    else begin
      slot = p*ND + (head[p] + count[p]) % ND;
      if (write_pos < FMAX) begin
        samples[slot*FMAX + write_pos] = s; write_pos++;
      end
      if (fe) begin
        if (count[p] >= ND) begin
          drop_oldest(p); st = pjbm_pkg::ST_EVICTED;
          slot = p*ND + (head[p] + count[p]) % ND;
        end
        slot_len[slot] = write_pos; count[p]++;
      end
    end
    if (fe) begin
      in_frame = 0; rejecting = 0; write_pos = 0;
    end
    return st;
  endfunction

  function automatic void apply_play(output logic signed [15:0] mix, output logic lst);
    int len, sum, slot;
    len = length_cfg;
    sum = 0;
    if (len == 0) len = 1;
    if (len > FMAX) len = FMAX;
    if (play_pos == 0) begin
      sel_mask = '0;
      for (int p = 0; p < NP; p++) begin
        if (!present[p]) continue;
        if (priming[p]) begin
          if (count[p] < depth_cfg) continue;
          priming[p] = 0;
        end
        if (count[p] == 0) begin
          underruns = sat_inc(underruns); priming[p] = 1; continue;
        end
        sel_mask[p] = 1;
      end
    end
    for (int p = 0; p < NP; p++) begin
      if (!sel_mask[p]) continue;
      slot = p*ND + head[p];
      if (play_pos < slot_len[slot]) sum += samples[slot*FMAX + play_pos];
    end
    lst = (play_pos + 1 >= len);
    if (lst) begin
      for (int p = 0; p < NP; p++) begin
        if (!sel_mask[p] || count[p] == 0) continue;
        head[p] = (head[p] + 1) % ND; count[p]--;
      end
      sel_mask = '0; play_pos = 0;
    end else play_pos++;
    if (sum > pjbm_pkg::SAMPLE_MAX) sum = pjbm_pkg::SAMPLE_MAX;
    if (sum < pjbm_pkg::SAMPLE_MIN) sum = pjbm_pkg::SAMPLE_MIN;
    mix = 16'(sum);
  endfunction

  // Predict on every accepted item and register write; compare each result.
  always @(posedge clk_i or negedge rst_ni) begin
    mix_result_t r, got;
    if (!rst_ni) begin
      depth_cfg = 2; length_cfg = 960;
      for (int p = 0; p < NP; p++) begin
        present[p] = 0; seen[p] = 0; last_seq[p] = 0; priming[p] = 1;
        head[p] = 0; count[p] = 0;
      end
      for (int i = 0; i < NP*ND; i++) slot_len[i] = 0;
      sel_mask = '0; play_pos = 0; write_pos = 0; in_frame = 0; rejecting = 0;
      underruns = 0; discards = 0;
      exp_rd = 0; exp_wr = 0;
      fail_count = 0;
    end else begin
      if (done_o) begin
        got = '{mixed_sample_o, frame_last_o, push_status_o, underrun_count_o,
                discard_count_o};
        if (exp_wr == exp_rd) begin
          fail_count++;
          $display("%0t: unexpected result %h", $realtime, got);
        end else begin
          r = exp_ring[exp_rd % EXP_DEPTH];
          exp_rd++;
          if (got !== r) begin
            fail_count++;
            $display("%0t: mismatch expected mix %0d last %0d st %0d und %0d dis %0d",
                     $realtime, r.mixed, r.last, r.status, r.underruns, r.discards);
            $display("%0t:            actual mix %0d last %0d st %0d und %0d dis %0d",
                     $realtime, got.mixed, got.last, got.status, got.underruns,
                     got.discards);
          end
        end
      end
      if (psel && penable && pwrite) begin
        if (paddr[2] == pjbm_pkg::REG_FRAME_LENGTH) length_cfg = pwdata[10:0];
        else depth_cfg = pwdata[2:0];
      end
      if (start_i && !busy_o) begin
        r = '{16'sd0, 1'b0, pjbm_pkg::ST_NOPUSH, 32'd0, 32'd0};
        case (action_i)
          pjbm_pkg::ACT_PUSH:
            r.status = apply_push(peer_i, sequence_req_i, sample_in_i, frame_end_i);
          pjbm_pkg::ACT_PLAY: apply_play(r.mixed, r.last);
          pjbm_pkg::ACT_DROP: begin
            present[peer_i] = 0; seen[peer_i] = 0; last_seq[peer_i] = 0;
            priming[peer_i] = 1; head[peer_i] = 0; count[peer_i] = 0;
            sel_mask[peer_i] = 0; in_frame = 0; rejecting = 0; write_pos = 0;
          end
          default: ;
        endcase
        r.underruns = underruns;
        r.discards = discards;
        exp_ring[exp_wr % EXP_DEPTH] = r;
        exp_wr++;
      end
    end
  end
endmodule

// ===== sim/testbench.sv =====
// Stimulus top that drives the jitter buffer mixer and reports the verdict.
`timescale 1ns / 1ps
module testbench;
  localparam logic [2:0] ADDR_DEPTH  = 3'(4 * pjbm_pkg::REG_PRIME_DEPTH);
  localparam logic [2:0] ADDR_LENGTH = 3'(4 * pjbm_pkg::REG_FRAME_LENGTH);

  logic               clk_i = 0;
  logic               rst_ni = 0;
  logic               start_i = 0;
  logic [1:0]         action_i = pjbm_pkg::ACT_PUSH;
  logic [2:0]         peer_i = 0;
  logic [31:0]        sequence_req_i = 0;
  logic signed [15:0] sample_in_i = 0;
  logic               frame_end_i = 0;
  logic               psel = 0, penable = 0, pwrite = 0;
  logic [2:0]         paddr = 0;
  logic [31:0]        pwdata = 0;
  logic               busy_o, done_o, frame_last_o, pready;
  logic signed [15:0] mixed_sample_o;
  logic [1:0]         push_status_o;
  logic [31:0]        underrun_count_o, discard_count_o, prdata;
  int                 fail_count, pending_results;
  int                 idle_pct;
  int                 cycle_count = 0;
  logic [31:0]        next_seq [8];

  always #6 clk_i = ~clk_i;

  peer_jitter_buffer_mixer u_dut (.*);
  mixer_checker u_check (.*);

  // Watchdog on total run length.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic reg_write(logic [2:0] addr, logic [31:0] data);
    @(negedge clk_i);
    psel <= 1; pwrite <= 1; paddr <= addr; pwdata <= data;
    @(negedge clk_i);
    penable <= 1;
    @(negedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  // One item transfer; start stays high across back-to-back items.
  task automatic send_item(logic [1:0] act, logic [2:0] p, logic [31:0] sq,
                           logic [15:0] s, logic fe);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 0;
      @(negedge clk_i);
    end
    start_i <= 1; action_i <= act; peer_i <= p; sequence_req_i <= sq;
    sample_in_i <= s; frame_end_i <= fe;
    do @(posedge clk_i); while (busy_o);
    @(negedge clk_i);
  endtask

  task automatic push_frame(logic [2:0] p, logic [31:0] sq, int n);
    for (int i = 0; i < n; i++) begin
      send_item(pjbm_pkg::ACT_PUSH, p, sq, 16'($urandom), i == n - 1);
    end
  endtask

  task automatic wait_idle();
    start_i <= 0;
    while (pending_results != 0) @(negedge clk_i);
    repeat (30) @(negedge clk_i);
  endtask

  initial begin
    int n, p, r, pc, len;
    idle_pct = 0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1;
    // Directed part with two-sample playback frames and a priming depth of one.
    reg_write(ADDR_LENGTH, 32'd2);
    reg_write(ADDR_DEPTH, 32'd1);
    send_item(pjbm_pkg::ACT_PUSH, 3'd0, 32'hFFFF_FFFF, 16'h7FFF, 1'b1);
    send_item(pjbm_pkg::ACT_PUSH, 3'd1, 32'd5, 16'h7FFF, 1'b0);
    send_item(pjbm_pkg::ACT_PUSH, 3'd1, 32'd5, 16'h8000, 1'b1);
    send_item(pjbm_pkg::ACT_PUSH, 3'd0, 32'd3, 16'h1234, 1'b0);   // stale frame
    send_item(pjbm_pkg::ACT_PUSH, 3'd0, 32'd3, 16'h1234, 1'b1);
    send_item(pjbm_pkg::ACT_PLAY, 3'd0, 32'd0, 16'd0, 1'b0);
    send_item(pjbm_pkg::ACT_PLAY, 3'd0, 32'd0, 16'd0, 1'b0);
    send_item(pjbm_pkg::ACT_PLAY, 3'd0, 32'd0, 16'd0, 1'b0);      // underrun on peer 0
    send_item(pjbm_pkg::ACT_UNDEF, 3'd7, 32'd0, 16'hFFFF, 1'b1);  // undefined action
    for (int i = 0; i < 5; i++) push_frame(3'd2, 32'd10 + 32'(i), 1); // eviction
    send_item(pjbm_pkg::ACT_DROP, 3'd2, 32'd0, 16'd0, 1'b0);
    send_item(pjbm_pkg::ACT_PUSH, 3'd3, 32'd1, 16'h8000, 1'b0);   // peer switch mid-frame
    send_item(pjbm_pkg::ACT_PUSH, 3'd4, 32'd1, 16'h8000, 1'b1);
    send_item(pjbm_pkg::ACT_PLAY, 3'd0, 32'd0, 16'd0, 1'b0);
    send_item(pjbm_pkg::ACT_PLAY, 3'd0, 32'd0, 16'd0, 1'b0);
    wait_idle();
    for (int i = 0; i < 8; i++) send_item(pjbm_pkg::ACT_DROP, 3'(i), 32'd0, 16'd0, 1'b0);
    wait_idle();
    for (int i = 0; i < 8; i++) next_seq[i] = 1;
    // Random phases with various settings and idling.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin reg_write(ADDR_DEPTH, 32'd0); reg_write(ADDR_LENGTH, 32'd0); end
        1: begin reg_write(ADDR_DEPTH, 32'd4); reg_write(ADDR_LENGTH, 32'd3); end
        2: begin reg_write(ADDR_DEPTH, 32'd7); reg_write(ADDR_LENGTH, 32'd2047); end
        3: begin reg_write(ADDR_DEPTH, 32'd1); reg_write(ADDR_LENGTH, 32'd1024); end
        default: begin
          reg_write(ADDR_DEPTH, $urandom_range(1, 4));
          reg_write(ADDR_LENGTH, $urandom_range(1, 6));
        end
      endcase
      idle_pct = (ph % 4 == 1) ? 51 : (ph % 4 == 2) ? 6 : 0;
      n = (ph == 2 || ph == 3) ? 40 : 155;
      pc = 0;
      while (pc < n) begin
        r = $urandom_range(99);
        p = $urandom_range(7);
        if (r < 45) begin
          // Well-formed frame, occasionally stale.
          len = $urandom_range(1, 7);
          if (ph == 2 || ph == 3) len = $urandom_range(1, 3);
          if ($urandom_range(9) == 0) next_seq[p] = next_seq[p] - 32'd2;
          push_frame(3'(p), next_seq[p], len);
          next_seq[p] = next_seq[p] + 32'd1 + $urandom_range(1);
          pc += len;
        end else if (r < 90) begin
          send_item(pjbm_pkg::ACT_PLAY, 3'd0, 32'd0, 16'd0, 1'b0); pc++;
        end else if (r < 94) begin
          send_item(pjbm_pkg::ACT_DROP, 3'(p), 32'd0, 16'd0, 1'b0);
          next_seq[p] = $urandom; pc++;
        end else begin
          send_item(2'($urandom), 3'(p), $urandom, 16'($urandom), 1'($urandom)); pc++;
          if (next_seq[p] == 0) next_seq[p] = 1;
        end
      end
      wait_idle();
    end
    wait_idle();
    if (fail_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
